/* design/arw_pkg.sv */
// shared constants and types for the anti-replay window block
package arw_pkg;

  localparam int unsigned WindowBits = 64;
  localparam int unsigned SeqWidth   = 32;
  localparam int unsigned TimeWidth  = 32;

  localparam logic [TimeWidth-1:0] IdleLimitRst = TimeWidth'(3000);

  // per-transaction control from the pipeline into the window
  typedef struct packed {
    logic fire;        // item leaves the input register this cycle
    logic pkt_valid;   // item carries an authenticated packet
    logic hist_clear;  // idle limit fired, drop the sequence history first
  } win_ctrl_t;

endpackage

/* design/anti_replay_window_with_idle_reset.sv */
// top level: anti-replay window with idle session expiry
//
// input channel: in_valid_i/in_ready_o move one receive event per transaction
//   (packet_valid_i, sequence_req_i, now_ms_i)
// output channel: out_valid_o/out_ready_i move one result per transaction
//   (accepted_o, session_expired_o), exactly one per input, in order
// config: cfg_we_i loads cfg_wdata_i into the idle limit in the same cycle;
//   write only while no transaction is in flight
// latency: 1 cycle from input acceptance to the result on the output port
// throughput: 1 transaction per cycle; the window check, the bitmap shift and
//   the idle compare all sit between the input register and the result register
// stall: while the result register is full and not taken, the input register
//   holds its item and in_ready_o drops only when both are occupied
// reset: idle limit back to 3000 ms, link idle, sequence history and window
//   cleared, both pipeline registers empty
module anti_replay_window_with_idle_reset #(
  parameter int unsigned WINDOW_BITS = arw_pkg::WindowBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [arw_pkg::TimeWidth-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           packet_valid_i,
  input  logic [arw_pkg::SeqWidth-1:0]   sequence_req_i,
  input  logic [arw_pkg::TimeWidth-1:0]  now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           accepted_o,
  output logic                           session_expired_o
);

  localparam int unsigned TW = arw_pkg::TimeWidth;

  // idle limit register
  logic [TW-1:0] idle_limit_q;

  // input register
  logic                         s1_valid_q;
  logic                         s1_pkt_q;
  logic [arw_pkg::SeqWidth-1:0] s1_seq_q;
  logic [TW-1:0]                s1_now_q;

  // session state
  logic          link_live_q, link_live_d;
  logic [TW-1:0] last_accept_q, last_accept_d;

  // result register
  logic out_valid_q, accepted_q, expired_q;

  logic               out_free, s1_fire, in_fire;
  logic [TW-1:0]      elapsed;
  logic               expire;
  logic               win_acc;
  arw_pkg::win_ctrl_t win_ctrl;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // idle check runs before the window, elapsed time wraps modulo 2^32
  assign elapsed = s1_now_q - last_accept_q;
  assign expire  = link_live_q && (elapsed >= idle_limit_q);

  assign win_ctrl.fire       = s1_fire;
  assign win_ctrl.pkt_valid  = s1_pkt_q;
  assign win_ctrl.hist_clear = expire;

  arw_window #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (win_ctrl),
    .seq_i   (s1_seq_q),
    .accept_o(win_acc)
  );

  // an accepted packet refreshes the timer, an expiry drops the link
  always_comb begin
    link_live_d   = link_live_q;
    last_accept_d = last_accept_q;
    if (win_acc) begin
      link_live_d   = 1'b1;
      last_accept_d = s1_now_q;
    end else if (expire) begin
      link_live_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= arw_pkg::IdleLimitRst;
    end else if (cfg_we_i) begin
      idle_limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pkt_q <= packet_valid_i;
      s1_seq_q <= sequence_req_i;
      s1_now_q <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_live_q   <= 1'b0;
      last_accept_q <= '0;
    end else if (s1_fire) begin
      link_live_q   <= link_live_d;
      last_accept_q <= last_accept_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      accepted_q <= win_acc;
      expired_q  <= expire;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = accepted_q;
  assign session_expired_o = expired_q;

`ifndef NO_ASSERTIONS
  a_accept_refreshes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && win_acc |=> link_live_q && (last_accept_q == $past(s1_now_q)))
    else $error("accepted packet did not refresh the session");

  a_expire_drops_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && expire && !win_acc |=> !link_live_q)
    else $error("link still live after idle expiry");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_seq_q) && $stable(s1_now_q))
    else $error("input register lost a pending transaction");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q && (accepted_q == $past(win_acc))
               && (expired_q == $past(expire)))
    else $error("result register does not match the processed transaction");
`endif

endmodule

/* design/arw_window.sv */
// sliding anti-replay window: highest sequence, seen bitmap and history flag
module arw_window #(
  parameter int unsigned WINDOW_BITS = arw_pkg::WindowBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  arw_pkg::win_ctrl_t            ctrl_i,
  input  logic [arw_pkg::SeqWidth-1:0]  seq_i,
  output logic                          accept_o
);

  localparam int unsigned IdxW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
  localparam int unsigned SW   = arw_pkg::SeqWidth;
  localparam logic [SW-1:0] WinSize = SW'(WINDOW_BITS);
  localparam logic [WINDOW_BITS-1:0] OneBit = WINDOW_BITS'(1);

  logic [SW-1:0]          highest_q, highest_d;
  logic [WINDOW_BITS-1:0] bitmap_q, bitmap_d;
  logic                   hv_q, hv_d;

  logic                   hv_eff;
  logic                   newer;
  logic [SW-1:0]          up_diff, up_m1, dn_diff, dn_m1;
  logic                   up_shift_ok, up_mark_ok, old_ok, old_seen;
  logic [IdxW-1:0]        up_amt, up_idx, dn_idx;
  logic [WINDOW_BITS-1:0] up_shifted, up_mark, dn_mark;

  assign hv_eff  = hv_q && !ctrl_i.hist_clear;
  assign newer   = seq_i > highest_q;

  // newer sequence: slide the window forward
  assign up_diff     = seq_i - highest_q;
  assign up_m1       = up_diff - SW'(1);
  assign up_shift_ok = up_diff < WinSize;
  assign up_mark_ok  = up_diff <= WinSize;
  assign up_amt      = up_diff[IdxW-1:0];
  assign up_idx      = up_m1[IdxW-1:0];
  assign up_shifted  = up_shift_ok ? (bitmap_q << up_amt) : '0;
  assign up_mark     = up_mark_ok ? (OneBit << up_idx) : '0;

  // older sequence: look up its bit
  assign dn_diff  = highest_q - seq_i;
  assign dn_m1    = dn_diff - SW'(1);
  assign old_ok   = (dn_diff != '0) && (dn_diff <= WinSize);
  assign dn_idx   = dn_m1[IdxW-1:0];
  assign old_seen = old_ok && bitmap_q[dn_idx];
  assign dn_mark  = OneBit << dn_idx;

  always_comb begin
    accept_o  = 1'b0;
    highest_d = highest_q;
    bitmap_d  = bitmap_q;
    hv_d      = hv_eff;
    if (ctrl_i.pkt_valid) begin
      if (!hv_eff) begin
        // first packet of a session
        accept_o  = 1'b1;
        highest_d = seq_i;
        bitmap_d  = '0;
        hv_d      = 1'b1;
      end else if (newer) begin
        accept_o  = 1'b1;
        highest_d = seq_i;
        bitmap_d  = up_shifted | up_mark;
      end else if (old_ok && !old_seen) begin
        accept_o  = 1'b1;
        bitmap_d  = bitmap_q | dn_mark;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q <= '0;
      bitmap_q  <= '0;
      hv_q      <= 1'b0;
    end else if (ctrl_i.fire) begin
      highest_q <= highest_d;
      bitmap_q  <= bitmap_d;
      hv_q      <= hv_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_sets_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fire && accept_o |=> hv_q)
    else $error("history flag not set after an accepted packet");

  a_no_pkt_keeps_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fire && !ctrl_i.pkt_valid |=> $stable(highest_q) && $stable(bitmap_q))
    else $error("window changed on an item without a packet");

  a_accept_needs_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_o |-> ctrl_i.pkt_valid)
    else $error("accept raised without a packet");

  a_clear_drops_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fire && ctrl_i.hist_clear && !accept_o |=> !hv_q)
    else $error("history survived an idle expiry");
`endif

endmodule

/* verif/anti_replay_window_with_idle_reset_tb.sv */
// testbench for the anti-replay window with idle session expiry
module anti_replay_window_with_idle_reset_tb;

  // result of one receive event as the block should report it
  typedef struct packed {
    logic accepted;
    logic expired;
  } verdict_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [arw_pkg::TimeWidth-1:0] cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic                          packet_valid_i = 1'b0;
  logic [arw_pkg::SeqWidth-1:0]  sequence_req_i = '0;
  logic [arw_pkg::TimeWidth-1:0] now_ms_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          accepted_o;
  logic                          session_expired_o;

  anti_replay_window_with_idle_reset uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .packet_valid_i    (packet_valid_i),
    .sequence_req_i    (sequence_req_i),
    .now_ms_i          (now_ms_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .accepted_o        (accepted_o),
    .session_expired_o (session_expired_o)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the session state, updated when a transaction is accepted
  logic [arw_pkg::TimeWidth-1:0]  idle_limit_ms;
  logic [arw_pkg::SeqWidth-1:0]   highest_seq;
  logic [arw_pkg::WindowBits-1:0] seen_mask;
  logic                           history_ok;
  logic [arw_pkg::TimeWidth-1:0]  last_accept_ms;
  logic                           link_up;

  verdict_t pending_verdicts[$];
  verdict_t oldest_verdict;
  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;

  // steady mode: no input gaps and no output stalls
  bit steady = 1'b0;
  int unsigned stall_left = 0;
  int unsigned ready_roll;

  // advance the shadow state by one receive event and return its verdict
  function automatic verdict_t window_verdict(logic pv, logic [arw_pkg::SeqWidth-1:0] seq,
                                              logic [arw_pkg::TimeWidth-1:0] now);
    verdict_t v;
    logic [arw_pkg::TimeWidth-1:0] elapsed;
    logic [arw_pkg::SeqWidth-1:0] delta;
    logic fresh;
    v = '0;
    fresh = 1'b0;
    elapsed = now - last_accept_ms;
    // idle check comes first, even when a packet rides on the same event
    if (link_up && elapsed >= idle_limit_ms) begin
      link_up = 1'b0;
      history_ok = 1'b0;
      v.expired = 1'b1;
    end
    if (pv) begin
      if (!history_ok) begin
        // first packet of a session always passes
        history_ok = 1'b1;
        highest_seq = seq;
        seen_mask = '0;
        fresh = 1'b1;
      end else if (seq > highest_seq) begin
        // newer sequence: slide the window, old highest lands at delta-1
        delta = seq - highest_seq;
        if (delta >= arw_pkg::WindowBits) seen_mask = '0;
        else seen_mask = seen_mask << delta;
        if (delta - 1 < arw_pkg::WindowBits) seen_mask[delta - 1] = 1'b1;
        highest_seq = seq;
        fresh = 1'b1;
      end else begin
        // older or equal: only an unseen slot inside the window passes
        delta = highest_seq - seq;
        if (delta != 0 && delta <= arw_pkg::WindowBits && !seen_mask[delta - 1]) begin
          seen_mask[delta - 1] = 1'b1;
          fresh = 1'b1;
        end
      end
    end
    if (fresh) begin
      v.accepted = 1'b1;
      last_accept_ms = now;
      link_up = 1'b1;
    end
    return v;
  endfunction

  // idle length for the input side: mostly none or short, now and then long
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one transaction on the input channel; returns at the edge that takes it
  task automatic send_event(logic pv, logic [arw_pkg::SeqWidth-1:0] seq,
                            logic [arw_pkg::TimeWidth-1:0] now);
    int unsigned gap;
    gap = gap_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    packet_valid_i <= pv;
    sequence_req_i <= seq;
    now_ms_i       <= now;
    do @(posedge clk_i); while (!in_ready_o);
    pending_verdicts.push_back(window_verdict(pv, seq, now));
  endtask

  // register write only once the pipeline has drained
  task automatic set_idle_limit(logic [arw_pkg::TimeWidth-1:0] limit);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    idle_limit_ms = limit;
  endtask

  task automatic note_mismatch(string what, verdict_t want);
    fail_count++;
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s): expected accepted=%0b expired=%0b, got accepted=%0b expired=%0b",
               what, want.accepted, want.expired, accepted_o, session_expired_o);
  endtask

  // output side: random stalls, a few of them long, none in steady mode
  always @(posedge clk_i) begin
    if (steady) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 70) begin
        out_ready_i <= 1'b1;
      end else if (ready_roll < 96) begin
        stall_left = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        stall_left = $urandom_range(10, 40);
        out_ready_i <= 1'b0;
      end
    end
  end

  // result checker: every output transaction against the oldest verdict
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch("no transaction pending", '0);
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        if (accepted_o !== oldest_verdict.accepted ||
            session_expired_o !== oldest_verdict.expired)
          note_mismatch("wrong result", oldest_verdict);
      end
    end
  end

  // window rules at the reset idle limit of 3000 ms
  task automatic test_directed_window();
    send_event(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // no packet on an idle link
    send_event(1'b1, 32'd100, 32'd10);              // first of session
    send_event(1'b1, 32'd100, 32'd11);              // newest repeated
    send_event(1'b1, 32'd99, 32'd12);               // older, unseen
    send_event(1'b1, 32'd99, 32'd13);               // duplicate
    send_event(1'b1, 32'd36, 32'd14);               // oldest slot of the window
    send_event(1'b1, 32'd35, 32'd15);               // too old by one
    send_event(1'b1, 32'd164, 32'd16);              // jump of exactly the window
    send_event(1'b1, 32'd100, 32'd17);              // old highest kept in top bit
    send_event(1'b1, 32'd101, 32'd18);
    send_event(1'b1, 32'd165, 32'd19);
    send_event(1'b1, 32'hFFFF_FFFF, 32'd20);        // big jump to the top sequence
    send_event(1'b1, 32'd0, 32'd21);                // no wrap-around ordering
    send_event(1'b0, 32'd0, 32'd3019);              // one below the idle limit
    send_event(1'b0, 32'd0, 32'd3020);              // idle limit reached
    send_event(1'b1, 32'd5, 32'd3021);              // new session takes a low sequence
    send_event(1'b1, 32'd7, 32'd6021);              // expire and accept together
    send_event(1'b1, 32'd0, 32'hFFFF_FF00);
    send_event(1'b1, 32'd1, 32'h0000_0010);         // elapsed time across the wrap
    send_event(1'b1, 32'd0, 32'h0000_0010);
  endtask

  // idle limit of one, the largest idle limit and zero
  task automatic test_idle_limit_extremes();
    set_idle_limit(32'd1);
    send_event(1'b1, 32'd500, 32'd1000);
    send_event(1'b1, 32'd501, 32'd1000);            // no time passed, stays live
    send_event(1'b1, 32'd502, 32'd1001);            // one ms is enough
    set_idle_limit(32'hFFFF_FFFF);
    send_event(1'b1, 32'd10, 32'd0);
    send_event(1'b0, 32'd0, 32'hFFFF_FFFE);
    send_event(1'b0, 32'd0, 32'hFFFF_FFFF);         // longest elapsed time
    set_idle_limit(32'd0);
    send_event(1'b1, 32'd3, 32'd5);
    send_event(1'b1, 32'd4, 32'd5);                 // live link expires every item
    send_event(1'b0, 32'd0, 32'd5);
  endtask

  // mostly well-formed traffic: rising sequences with reordering and replays,
  // time creeping forward with now and then a stop right at the idle limit
  task automatic random_traffic(logic [arw_pkg::TimeWidth-1:0] limit, int unsigned count);
    logic [arw_pkg::TimeWidth-1:0] clock_ms;
    logic [arw_pkg::TimeWidth-1:0] step_max;
    logic [arw_pkg::SeqWidth-1:0] seq;
    logic pv;
    int unsigned r;
    set_idle_limit(limit);
    clock_ms = $urandom();
    step_max = (limit >> 4) + 2;
    for (int unsigned n = 0; n < count; n++) begin
      pv = ($urandom_range(0, 99) >= 8);
      r = $urandom_range(0, 99);
      if (r < 45) seq = highest_seq + $urandom_range(1, 3);
      else if (r < 75) seq = highest_seq - $urandom_range(0, 70);
      else if (r < 85) seq = highest_seq + $urandom_range(4, 70);
      else if (r < 92) seq = highest_seq + $urandom_range(63, 65);
      else seq = $urandom();
      r = $urandom_range(0, 99);
      if (r < 80) clock_ms = clock_ms + $urandom_range(0, step_max);
      else if (r < 92) clock_ms = last_accept_ms + limit - $urandom_range(0, 1);
      else clock_ms = $urandom();
      send_event(pv, seq, clock_ms);
    end
  endtask

  task automatic test_random_traffic();
    random_traffic(32'd3000, 120);
    random_traffic($urandom_range(20, 500), 120);
    random_traffic(32'd1, 80);
    random_traffic($urandom() | 32'h8000_0000, 80);
    random_traffic(32'hFFFF_FFFF, 80);
  endtask

  // full rate on both channels with no gaps and no stalls, then normal traffic
  task automatic test_back_to_back();
    steady = 1'b1;
    random_traffic(32'd200, 60);
    steady = 1'b0;
    random_traffic(32'd3000, 40);
  endtask

  initial begin
    // shadow state matches the block after reset
    idle_limit_ms  = arw_pkg::IdleLimitRst;
    highest_seq    = '0;
    seen_mask      = '0;
    history_ok     = 1'b0;
    last_accept_ms = '0;
    link_up        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_window();
    test_idle_limit_extremes();
    test_random_traffic();
    test_back_to_back();

    // drain and let the pipeline settle
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
